### design/shp_pkg.sv
// Shared shape codes and pipeline control type for the shape hit test.
package shp_pkg;

   localparam int CMD_WIDTH = 2;

   localparam logic [CMD_WIDTH-1:0] CMD_BOX     = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_ELLIPSE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_ROUNDED = 2'd2;

   // Control that travels down the pipeline beside the data.
   typedef struct packed {
      logic                 valid;
      logic                 inbox;
      logic [CMD_WIDTH-1:0] cmd;
   } ctrl_type;

endpackage

### design/shape_hit_test.sv
// Shape hit test: point in box, ellipse or rounded rectangle, four-stage pipeline.
//
// Usage: drive req_command, req_corner_radius, req_point_x/y and
// req_box_width/height and raise start. A transfer happens at every rising
// edge with start high and busy low; busy never rises, so a new test can
// enter on every cycle. Each test gives one result: rsp_valid is high for
// exactly one cycle with rsp_hit, and the result transfers at the edge
// that ends that cycle.
// Throughput is one test per cycle.
// The stages are: box check and offsets; products (w*h, a*h, b*w) and
// rounded corner distances; squares; sum and compare. The 30 by 30 bit
// squaring of the ellipse terms sets the stage depth.
// Results leave in the order their items entered.
// Reset clears the valid bits in every stage; items in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module shape_hit_test #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [shp_pkg::CMD_WIDTH-1:0] req_command,
   input  logic [COORD_WIDTH-2:0]        req_corner_radius,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_width,
   input  logic signed [COORD_WIDTH-1:0] req_box_height,
   output logic                          rsp_valid,
   output logic                          rsp_hit
);

   import shp_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int DW = 2 * (CW - 1);

   // Stage 1 signals.
   ctrl_type                c1_in, c1_ff;
   logic signed [CW:0]      ex, ey;
   logic [CW-2:0]           a1_in, b1_in, a1_ff, b1_ff;
   logic [CW-2:0]           w1_ff, h1_ff;
   logic [CW-1:0]           tx1_in, ty1_in, tx1_ff, ty1_ff;
   logic signed [CW-1:0]    m_s;
   logic [CW-1:0]           radius2;
   logic [CW-2:0]           r21_in, r21_ff;

   // Stage 2 signals.
   ctrl_type                c2_ff;
   logic [CW-1:0]           hix, hiy;
   logic [CW-2:0]           dx2_in, dy2_in, dx2_ff, dy2_ff, r22_ff;

   // Stage 3 and 4 signals.
   ctrl_type                c3_ff;
   logic [DW-1:0]           dxx3_ff, dyy3_ff, rr3_ff;
   logic [DW:0]             dsum;
   logic                    ell_inside;
   logic                    round_inside;
   logic                    hit_in;
   logic                    rsp_valid_ff, rsp_hit_ff;

   assign busy = 1'b0;

   // Stage 1: closed-box check, ellipse offsets, doubled radius clamp.
   always_comb begin
      c1_in.valid = start & ~busy;
      c1_in.inbox = (req_box_width > 0) && (req_box_height > 0) &&
                    (req_point_x >= 0) && (req_point_y >= 0) &&
                    (req_point_x <= req_box_width) && (req_point_y <= req_box_height);
      c1_in.cmd   = req_command;
   end

   assign ex    = {req_point_x, 1'b0} - {req_box_width[CW-1], req_box_width};
   assign ey    = {req_point_y, 1'b0} - {req_box_height[CW-1], req_box_height};
   assign a1_in = ex[CW] ? (CW-1)'(-ex) : ex[CW-2:0];
   assign b1_in = ey[CW] ? (CW-1)'(-ey) : ey[CW-2:0];

   assign tx1_in  = {req_point_x[CW-2:0], 1'b0};
   assign ty1_in  = {req_point_y[CW-2:0], 1'b0};
   assign m_s     = (req_box_width < req_box_height) ? req_box_width : req_box_height;
   assign radius2 = {req_corner_radius, 1'b0};
   assign r21_in  = (radius2 > {1'b0, m_s[CW-2:0]}) ? m_s[CW-2:0] : radius2[CW-2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
      end else begin
         c1_ff <= c1_in;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff  <= a1_in;
      b1_ff  <= b1_in;
      w1_ff  <= req_box_width[CW-2:0];
      h1_ff  <= req_box_height[CW-2:0];
      tx1_ff <= tx1_in;
      ty1_ff <= ty1_in;
      r21_ff <= r21_in;
   end

   // Stage 2: distance from the doubled point to the inner rectangle.
   // A zero radius leaves the whole box as the inner rectangle, so it hits.
   assign hix = {w1_ff, 1'b0} - {1'b0, r21_ff};
   assign hiy = {h1_ff, 1'b0} - {1'b0, r21_ff};

   always_comb begin
      if (tx1_ff < {1'b0, r21_ff}) begin
         dx2_in = (CW-1)'({1'b0, r21_ff} - tx1_ff);
      end else if (tx1_ff > hix) begin
         dx2_in = (CW-1)'(tx1_ff - hix);
      end else begin
         dx2_in = '0;
      end
      if (ty1_ff < {1'b0, r21_ff}) begin
         dy2_in = (CW-1)'({1'b0, r21_ff} - ty1_ff);
      end else if (ty1_ff > hiy) begin
         dy2_in = (CW-1)'(ty1_ff - hiy);
      end else begin
         dy2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff <= '0;
         c3_ff <= '0;
      end else begin
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx2_ff <= dx2_in;
      dy2_ff <= dy2_in;
      r22_ff <= r21_ff;
   end

   // Stage 3: squares for the corner test.
   always_ff @(posedge clock) begin
      dxx3_ff <= DW'(dx2_ff * dx2_ff);
      dyy3_ff <= DW'(dy2_ff * dy2_ff);
      rr3_ff  <= DW'(r22_ff * r22_ff);
   end

   shp_ellipse #(
      .COORD_WIDTH(CW)
   ) u_ellipse (
      .clock       (clock),
      .dist_x      (a1_ff),
      .dist_y      (b1_ff),
      .size_w      (w1_ff),
      .size_h      (h1_ff),
      .hit_ellipse (ell_inside)
   );

   // Stage 4: compare and pick the result for the shape.
   assign dsum         = {1'b0, dxx3_ff} + {1'b0, dyy3_ff};
   assign round_inside = (dsum <= {1'b0, rr3_ff});

   always_comb begin
      case (c3_ff.cmd)
         CMD_ELLIPSE: hit_in = c3_ff.inbox & ell_inside;
         CMD_ROUNDED: hit_in = c3_ff.inbox & round_inside;
         default:     hit_in = c3_ff.inbox;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= c3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // Every transfer in comes out as a result.
   a_lat_fwd: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) &&
       !$past(reset, 4) && $past(start, 4)) |-> rsp_valid)
      else $error("accepted test produced no result");

   a_lat_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 4))
      else $error("result without an accepted test");

   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (($past(req_box_width, 4) <= 0) || ($past(req_box_height, 4) <= 0)))
      |-> !rsp_hit)
      else $error("hit reported for a degenerate box");

   a_box_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_command, 4) == CMD_BOX) &&
       ($past(req_box_width, 4) > 0) && ($past(req_box_height, 4) > 0) &&
       ($past(req_point_x, 4) >= 0) && ($past(req_point_y, 4) >= 0) &&
       ($past(req_point_x, 4) <= $past(req_box_width, 4)) &&
       ($past(req_point_y, 4) <= $past(req_box_height, 4))) |-> rsp_hit)
      else $error("point inside a plain box missed");

endmodule

### design/shp_ellipse.sv
// Ellipse inequality pipeline: products, squares, then the final compare.
module shp_ellipse #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                   clock,
   input  logic [COORD_WIDTH-2:0] dist_x,
   input  logic [COORD_WIDTH-2:0] dist_y,
   input  logic [COORD_WIDTH-2:0] size_w,
   input  logic [COORD_WIDTH-2:0] size_h,
   output logic                   hit_ellipse
);

   localparam int PW = 2 * (COORD_WIDTH - 1);
   localparam int SW = 2 * PW;

   logic [PW-1:0] p_ff, q_ff, s_ff;
   logic [PW-1:0] p_in, q_in, s_in;
   logic [SW-1:0] pp_ff, qq_ff, ss_ff;
   logic [SW-1:0] pp_in, qq_in, ss_in;
   logic [SW:0]   lhs;

   assign p_in = PW'(dist_x * size_h);
   assign q_in = PW'(dist_y * size_w);
   assign s_in = PW'(size_w * size_h);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      q_ff <= q_in;
      s_ff <= s_in;
   end

   assign pp_in = SW'(p_ff * p_ff);
   assign qq_in = SW'(q_ff * q_ff);
   assign ss_in = SW'(s_ff * s_ff);

   always_ff @(posedge clock) begin
      pp_ff <= pp_in;
      qq_ff <= qq_in;
      ss_ff <= ss_in;
   end

   // (2x-w)^2 h^2 + (2y-h)^2 w^2 <= w^2 h^2, all terms exact.
   assign lhs         = {1'b0, pp_ff} + {1'b0, qq_ff};
   assign hit_ellipse = (lhs <= {1'b0, ss_ff});

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the shape hit test: directed corners, then random shape queries.
module testbench;
   import shp_pkg::*;

   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [CMD_WIDTH-1:0] command;
      logic [14:0]          corner_radius;
      logic signed [15:0]   point_x;
      logic signed [15:0]   point_y;
      logic signed [15:0]   box_width;
      logic signed [15:0]   box_height;
   } hit_query_type;

   typedef struct {
      hit_query_type query;
      bit            hit;
   } hit_answer_type;

   logic                 clock;
   logic                 reset;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CMD_WIDTH-1:0] req_command = '0;
   logic [14:0]          req_corner_radius = '0;
   logic signed [15:0]   req_point_x = '0;
   logic signed [15:0]   req_point_y = '0;
   logic signed [15:0]   req_box_width = '0;
   logic signed [15:0]   req_box_height = '0;
   logic                 rsp_valid;
   logic                 rsp_hit;

   hit_query_type  pending_queries[$];
   hit_answer_type expected_hits[$];
   int             errors = 0;
   int             checked_per_command[4] = '{0, 0, 0, 0};
   int             hits_seen = 0;
   int             burst_left = 0;
   int             gap_left = 0;

   shape_hit_test #(.COORD_WIDTH(16)) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_corner_radius (req_corner_radius),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_box_width     (req_box_width),
      .req_box_height    (req_box_height),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Exact integer form of the shape tests; every comparison is scale invariant.
   function automatic bit predict_hit(hit_query_type q);
      longint      x, y, w, h, a, b;
      longint      side, r2, tx, ty, lo_x, hi_x, lo_y, hi_y, cx, cy, dx, dy;
      logic [127:0] p, r, s;
      x = q.point_x;
      y = q.point_y;
      w = q.box_width;
      h = q.box_height;
      if (w <= 0 || h <= 0 || x < 0 || y < 0 || x > w || y > h) begin
         return 1'b0;
      end
      case (q.command)
         CMD_ELLIPSE: begin
            a = (2 * x >= w) ? 2 * x - w : w - 2 * x;
            b = (2 * y >= h) ? 2 * y - h : h - 2 * y;
            p = a * h;
            r = b * w;
            s = w * h;
            return (p * p + r * r) <= s * s;
         end
         CMD_ROUNDED: begin
            side = (w < h) ? w : h;
            r2 = 2 * longint'(q.corner_radius);
            if (r2 > side) r2 = side;
            if (r2 == 0) return 1'b1;
            tx = 2 * x;
            ty = 2 * y;
            lo_x = r2;
            hi_x = 2 * w - r2;
            lo_y = r2;
            hi_y = 2 * h - r2;
            cx = (tx < lo_x) ? lo_x : ((tx > hi_x) ? hi_x : tx);
            cy = (ty < lo_y) ? lo_y : ((ty > hi_y) ? hi_y : ty);
            dx = (tx >= cx) ? tx - cx : cx - tx;
            dy = (ty >= cy) ? ty - cy : cy - ty;
            return dx * dx + dy * dy <= r2 * r2;
         end
         default: return 1'b1;
      endcase
   endfunction

   task automatic add_query(logic [CMD_WIDTH-1:0] cmd, int radius, int x, int y, int w, int h);
      hit_query_type q;
      q.command       = cmd;
      q.corner_radius = 15'(radius);
      q.point_x       = 16'(x);
      q.point_y       = 16'(y);
      q.box_width     = 16'(w);
      q.box_height    = 16'(h);
      pending_queries.push_back(q);
   endtask

   task automatic add_random_query();
      int kind, w, h, mx, my, radius;
      logic [CMD_WIDTH-1:0] cmd;
      kind = $urandom_range(0, 9);
      cmd  = CMD_WIDTH'($urandom_range(0, 3));
      if (kind < 2) begin
         // Noise over the whole field ranges, mostly degenerate or outside.
         add_query(cmd, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         if (kind < 5) begin
            w = $urandom_range(1, 64);
            h = $urandom_range(1, 64);
         end else begin
            w = $urandom_range(1, 32767);
            h = $urandom_range(1, 32767);
         end
         mx = w / 8 + 1;
         my = h / 8 + 1;
         case ($urandom_range(0, 3))
            0:       radius = 0;
            1:       radius = $urandom_range(0, 32767);
            default: radius = $urandom_range(0, (w < h) ? w : h);
         endcase
         add_query(cmd, radius, $urandom_range(0, w + 2 * mx) - mx,
                   $urandom_range(0, h + 2 * my) - my, w, h);
      end
   endtask

   initial begin
      // Directed corners: degenerate boxes, borders, extremes and the unused code.
      add_query(CMD_BOX, 0, 0, 0, 0, 10);
      add_query(CMD_ELLIPSE, 5, 0, 0, 10, 0);
      add_query(CMD_ROUNDED, 5, 1, 1, -32768, 100);
      add_query(CMD_BOX, 0, 5, 5, 100, -1);
      add_query(CMD_BOX, 0, -1, 5, 100, 100);
      add_query(CMD_BOX, 0, 5, -32768, 100, 100);
      add_query(CMD_BOX, 0, 101, 5, 100, 100);
      add_query(CMD_BOX, 0, 100, 100, 100, 100);
      add_query(CMD_BOX, 0, 0, 0, 1, 1);
      add_query(CMD_UNUSED, 32767, 50, 50, 100, 100);
      add_query(CMD_UNUSED, 0, 32767, 0, 32767, 32767);
      add_query(CMD_ELLIPSE, 0, 50, 50, 100, 100);
      add_query(CMD_ELLIPSE, 0, 0, 0, 100, 100);
      add_query(CMD_ELLIPSE, 0, 0, 50, 100, 100);
      add_query(CMD_ELLIPSE, 0, 32767, 16383, 32767, 32767);
      add_query(CMD_ELLIPSE, 0, 16384, 0, 32767, 32767);
      add_query(CMD_ELLIPSE, 0, 15, 15, 100, 100);
      add_query(CMD_ROUNDED, 0, 0, 0, 100, 100);
      add_query(CMD_ROUNDED, 32767, 0, 0, 100, 100);
      add_query(CMD_ROUNDED, 32767, 50, 50, 100, 100);
      add_query(CMD_ROUNDED, 10, 0, 10, 100, 100);
      add_query(CMD_ROUNDED, 10, 3, 3, 100, 100);
      add_query(CMD_ROUNDED, 32767, 32767, 32767, 32767, 32767);
      add_query(CMD_ROUNDED, 16383, 4800, 4800, 32767, 32767);
      add_query(CMD_ELLIPSE, 32767, -1, -1, 32767, 32767);
      repeat (1750) add_random_query();
   end

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin : drive_queries
      hit_query_type q;
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // Hold the current item until it transfers.
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start    <= 1'b0;
      end else if (pending_queries.size() > 0) begin
         q = pending_queries.pop_front();
         req_command       <= q.command;
         req_corner_radius <= q.corner_radius;
         req_point_x       <= q.point_x;
         req_point_y       <= q.point_y;
         req_box_width     <= q.box_width;
         req_box_height    <= q.box_height;
         start             <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         start <= 1'b0;
      end
   end

   // Checks each result against the oldest prediction, then records new transfers.
   always @(posedge clock) begin : check_hits
      hit_answer_type e;
      hit_query_type  q;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_hits.size() == 0) begin
               $display("%0t: result with no test pending, actual hit %0b", $time, rsp_hit);
               errors = errors + 1;
            end else begin
               e = expected_hits.pop_front();
               checked_per_command[e.query.command] += 1;
               if (rsp_hit) hits_seen = hits_seen + 1;
               if (rsp_hit !== e.hit) begin
                  $display({"%0t: hit mismatch (cmd %0d r %0d x %0d y %0d w %0d h %0d): ",
                            "expected %0b, actual %0b"},
                           $time, e.query.command, e.query.corner_radius, e.query.point_x,
                           e.query.point_y, e.query.box_width, e.query.box_height,
                           e.hit, rsp_hit);
                  errors = errors + 1;
               end
            end
         end
         if (start && !busy) begin
            q.command       = req_command;
            q.corner_radius = req_corner_radius;
            q.point_x       = req_point_x;
            q.point_y       = req_point_y;
            q.box_width     = req_box_width;
            q.box_height    = req_box_height;
            e.query = q;
            e.hit   = predict_hit(q);
            expected_hits.push_back(e);
         end
      end
   end

   initial begin
      @(negedge clock);
      while (reset || pending_queries.size() > 0 || start) @(negedge clock);
      while (expected_hits.size() > 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (expected_hits.size() > 0) begin
         $display("%0t: %0d results never arrived", $time, expected_hits.size());
         errors = errors + 1;
      end
      $display("tb: checked %0d box, %0d ellipse, %0d rounded and %0d unused-code tests",
               checked_per_command[0], checked_per_command[1], checked_per_command[2],
               checked_per_command[3]);
      $display("tb: %0d of them hit, %0d errors", hits_seen, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
